/* hdl/gini_pkg.sv */
// ----------------------------------------------------------------------------
// Gini index package
// Shared status codes and types for the sorted-chain Gini index block.
// ----------------------------------------------------------------------------
package gini_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_ZERO_SUM = 2'd2,
    ST_OVERFLOW = 2'd3
  } gini_status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SUM,
    FSM_MUL,
    FSM_LOAD,
    FSM_DIV,
    FSM_OUT
  } gini_fsm_t;

  localparam int GINI_VALUE_BITS = 16;
  localparam int COUNT_OUT_BITS  = 9;

  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } gini_chain_ctl_t;

endpackage

/* hdl/gini_cell.sv */
// ----------------------------------------------------------------------------
// Gini chain cell
// One slot of the sorted chain: inserts in order, then shifts out to sum.
// ----------------------------------------------------------------------------
module gini_cell #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gini_pkg::gini_chain_ctl_t ctl,
  input  logic [SAMPLE_BITS-1:0]   new_value,
  input  logic                     prev_valid,
  input  logic                     prev_greater,
  input  logic [SAMPLE_BITS-1:0]   prev_value,
  input  logic [SAMPLE_BITS-1:0]   next_value,
  input  logic                     next_valid,
  output logic                     valid,
  output logic                     greater,
  output logic [SAMPLE_BITS-1:0]   value
);
  import gini_pkg::*;

  logic [SAMPLE_BITS-1:0] value_r, value_nxt;
  logic                   valid_r, valid_nxt;

  assign greater = valid_r && (value_r > new_value);
  assign valid   = valid_r;
  assign value   = value_r;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctl.shift) begin
      value_nxt = next_value;
      valid_nxt = next_valid;
    end else if (ctl.insert) begin
      if (greater) begin
        if (prev_greater) value_nxt = prev_value;
        else value_nxt = new_value;
      end else if (!valid_r && prev_valid && !(prev_greater)) begin
        value_nxt = new_value;
        valid_nxt = 1'b1;
      end else if (!valid_r && prev_greater) begin
        value_nxt = prev_value;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
    value_r <= value_nxt;
  end

endmodule

/* hdl/gini_div.sv */
// ----------------------------------------------------------------------------
// Gini divider
// Restoring division, one quotient bit per cycle, 16 bits.
// ----------------------------------------------------------------------------
module gini_div #(
  parameter int ACC_BITS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [ACC_BITS-1:0] num,
  input  logic [ACC_BITS-1:0] den,
  output logic                done,
  output logic [15:0]         quot
);
  import gini_pkg::*;

  logic [ACC_BITS:0]   rem_r;
  logic [ACC_BITS-1:0] den_r;
  logic [15:0]         q_r;
  logic [4:0]          cnt_r;
  logic                run_r;
  logic [ACC_BITS:0]   sh;

  assign sh   = {rem_r[ACC_BITS-1:0], 1'b0};
  assign done = run_r && (cnt_r == 5'd16);
  assign quot = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= '0;
      rem_r <= {1'b0, num};
      den_r <= den;
      q_r   <= '0;
    end else if (run_r) begin
      if (cnt_r == 5'd16) begin
        run_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 5'd1;
        if (sh >= {1'b0, den_r}) begin
          rem_r <= sh - {1'b0, den_r};
          q_r   <= {q_r[14:0], 1'b1};
        end else begin
          rem_r <= sh;
          q_r   <= {q_r[14:0], 1'b0};
        end
      end
    end
  end

endmodule

/* hdl/gini_index_of_sample_set_top.sv */
// ----------------------------------------------------------------------------
// Gini index of sample set
// Sorted insertion chain, shift-out summation and serial division.
// ----------------------------------------------------------------------------
//  channel  | ports                                             | direction
//  input    | start, busy, in_sample_value/missing, in_set_last | in, busy out
//  result   | out_valid, out_gini_value/status/kept_count       | out
//
// One sample per cycle while collecting; busy stays low.
// On set_last: shift-out summing (FSM_SUM), one multiply state, one divider
// load state, the serial divider run and one output state, with busy high
// throughout.
// Reset empties the chain; the store needs no clearing pass.
// Results are shown for one cycle; the receiver cannot stall.
module gini_index_of_sample_set_top #(
  parameter int MAX_SAMPLES = 256,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [31:0]            in_sample_value,
  input  logic                   in_sample_missing,
  input  logic                   in_set_last,
  output logic                   out_valid,
  output logic [15:0]            out_gini_value,
  output logic [1:0]             out_result_status,
  output logic [8:0]             out_kept_count
);
  import gini_pkg::*;

  localparam int CNT_BITS = $clog2(MAX_SAMPLES + 1);
  localparam int ACC_BITS = 64;

  gini_fsm_t state_r, state_nxt;
  gini_chain_ctl_t ctl;

  logic [CNT_BITS-1:0]    count_r;
  logic [CNT_BITS-1:0]    idx_r;
  logic                   ovf_r;
  logic [ACC_BITS-1:0]    s_r, w_r, num_r, den_r;
  logic [SAMPLE_BITS-1:0] newv;
  logic                   accept, keep, full;

  logic [MAX_SAMPLES-1:0] vld, gt;
  logic [SAMPLE_BITS-1:0] val [MAX_SAMPLES];
  logic                   div_start, div_done;
  logic [15:0]            quot;
  gini_status_t           status;

  assign accept = start && !busy;
  assign full   = (count_r == CNT_BITS'(MAX_SAMPLES));
  assign keep   = accept && !in_sample_missing && !full;
  assign newv   = in_sample_value[SAMPLE_BITS-1:0];

  assign vld[0] = 1'b1;
  assign gt[0]  = 1'b0;
  assign val[0] = '0;

  always_comb begin
    ctl.insert = keep;
    ctl.shift  = (state_r == FSM_SUM);
    ctl.clear  = (state_r == FSM_OUT);
  end

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    logic             cv, cg;
    logic [SAMPLE_BITS-1:0] cval;
    gini_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .new_value(newv),
      .prev_valid(vld[i]), .prev_greater(gt[i]), .prev_value(val[i]),
      .next_value(i + 1 < MAX_SAMPLES ? g_cell[(i + 1) % MAX_SAMPLES].cval : '0),
      .next_valid(i + 1 < MAX_SAMPLES ? g_cell[(i + 1) % MAX_SAMPLES].cv : 1'b0),
      .valid(cv), .greater(cg), .value(cval)
    );
    if (i > 0) begin : g_link
      assign vld[i] = g_cell[i-1].cv;
      assign gt[i]  = g_cell[i-1].cg;
      assign val[i] = g_cell[i-1].cval;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: if (accept && in_set_last) state_nxt = FSM_SUM;
      FSM_SUM:  if (idx_r == CNT_BITS'(MAX_SAMPLES - 1)) state_nxt = FSM_MUL;
      FSM_MUL:  state_nxt = FSM_LOAD;
      FSM_LOAD: state_nxt = FSM_DIV;
      FSM_DIV:  if (div_done) state_nxt = FSM_OUT;
      FSM_OUT:  state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_r != FSM_IDLE);
    div_start = (state_r == FSM_LOAD);
    out_valid = (state_r == FSM_OUT);
  end

  always_comb begin
    if (ovf_r) status = ST_OVERFLOW;
    else if (count_r == '0) status = ST_EMPTY;
    else if (s_r == '0) status = ST_ZERO_SUM;
    else status = ST_OK;
  end

  assign out_result_status = status;
  assign out_gini_value    = (status != ST_OK) ? 16'd0 :
                             (num_r < den_r) ? quot : 16'hFFFF;
  assign out_kept_count    = 9'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (keep) count_r <= count_r + 1'b1;
      if (accept && !in_sample_missing && full) ovf_r <= 1'b1;
      if (state_r == FSM_SUM) idx_r <= idx_r + 1'b1;
      if (state_r == FSM_OUT) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
        idx_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_set_last) begin
      s_r <= '0;
      w_r <= '0;
    end else if (state_r == FSM_SUM && g_cell[0].cv) begin
      s_r <= s_r + ACC_BITS'(g_cell[0].cval);
      w_r <= w_r + ACC_BITS'(g_cell[0].cval) * ACC_BITS'(idx_r + 1'b1);
    end
    if (state_r == FSM_MUL) begin
      den_r <= ACC_BITS'(count_r) * s_r;
      num_r <= ((w_r << 1) > ACC_BITS'(count_r + 1'b1) * s_r)
             ? (w_r << 1) - ACC_BITS'(count_r + 1'b1) * s_r : '0;
    end
  end

  gini_div #(.ACC_BITS(ACC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(num_r), .den(den_r), .done(div_done), .quot(quot)
  );

  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside busy");
  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(MAX_SAMPLES)) else $error("count beyond capacity");

endmodule
